// ===== hdl/nla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_pkg
// Shared types, sizes and codes for the nearest landmark association block.
// ----------------------------------------------------------------------------
package nla_pkg;

  // Table and coordinate sizes
  localparam int MAX_LANDMARKS = 64;
  localparam int COORD_BITS    = 24;
  localparam int ID_BITS       = 16;
  localparam int DIST_BITS     = 50;

  localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);

  // Datapath widths: magnitude of a difference, its square, the sum
  localparam int MAG_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = (SQ_W + 1 > DIST_BITS + 1) ? SQ_W + 1 : DIST_BITS + 1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(MAX_LANDMARKS);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ID_BITS-1:0]    id;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } landmark_t;

  localparam int ENTRY_W = $bits(landmark_t);

endpackage

// ===== hdl/nla_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nla_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nearest_landmark_association.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_landmark_association
// Landmark table in RAM with clear, load and nearest-neighbor query commands.
// ----------------------------------------------------------------------------
//  channel   ports                                          handshake
//  command   command_i landmark_id_i point_x_i point_y_i    start & !busy
//  result    status_o nearest_id_o best_dist_sq_o           result_valid_o
//
//  Clear, load and unused commands, and a query on an empty table, give their
//  result word in the cycle after acceptance. During a query the RAM read
//  port delivers one entry per cycle into a three-stage difference, square
//  and compare pipeline. busy is high from query acceptance to its result.
//  Reset empties the table through the entry count; RAM contents are kept.
//  Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module nearest_landmark_association (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      command_i,
  input  logic [nla_pkg::ID_BITS-1:0]     landmark_id_i,
  input  logic signed [nla_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [nla_pkg::COORD_BITS-1:0] point_y_i,
  output logic                            result_valid_o,
  output logic [1:0]                      status_o,
  output logic [nla_pkg::ID_BITS-1:0]     nearest_id_o,
  output logic [nla_pkg::DIST_BITS-1:0]   best_dist_sq_o
);
  import nla_pkg::*;

  // Control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              first_q, first_d;
  logic              rd_v_q, diff_v_q, sq_v_q;
  logic              res_v_q, res_v_d;

  // Payload registers
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [MAG_W-1:0]      magx_q, magy_q;
  logic [ID_BITS-1:0]    id_diff_q, id_sq_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [DIST_BITS-1:0]  best_q, best_d;
  logic [ID_BITS-1:0]    best_id_q, best_id_d;
  status_e               stat_q, stat_d;
  logic [ID_BITS-1:0]    rid_q, rid_d;
  logic [DIST_BITS-1:0]  rdist_q, rdist_d;

  // RAM ports
  logic              ram_we, ram_re;
  landmark_t         wentry, rentry;
  logic [ENTRY_W-1:0] rdata;

  assign wentry = '{id: landmark_id_i, x: point_x_i, y: point_y_i};
  assign rentry = landmark_t'(rdata);

  nla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LANDMARKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Stage one: coordinate differences and their magnitudes
  logic [MAG_W-1:0] dx, dy, magx, magy;
  assign dx   = {px_q[COORD_BITS-1], px_q} - {rentry.x[COORD_BITS-1], rentry.x};
  assign dy   = {py_q[COORD_BITS-1], py_q} - {rentry.y[COORD_BITS-1], rentry.y};
  assign magx = dx[MAG_W-1] ? (~dx + MAG_W'(1)) : dx;
  assign magy = dy[MAG_W-1] ? (~dy + MAG_W'(1)) : dy;

  // Stage three: sum of squares, saturated to the distance width
  logic [SUM_W-1:0]     sum;
  logic [DIST_BITS-1:0] dist_sat;
  assign sum      = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign dist_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

  // Next state, RAM control and result word
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    first_d   = first_q;
    px_d      = px_q;
    py_d      = py_q;
    best_d    = best_q;
    best_id_d = best_id_q;
    res_v_d   = 1'b0;
    stat_d    = stat_q;
    rid_d     = rid_q;
    rdist_d   = rdist_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    // Keep the closest entry; a later one must be strictly closer
    if (sq_v_q && (first_q || (dist_sat < best_q))) begin
      best_d    = dist_sat;
      best_id_d = id_sq_q;
      first_d   = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_v_d = 1'b1;
          stat_d  = STAT_OK;
          rid_d   = '0;
          rdist_d = '0;
          unique case (command_i)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_LOAD: begin
              if (count_q >= CNT_FULL) begin
                stat_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                stat_d = STAT_EMPTY;
              end else begin
                res_v_d = 1'b0;
                px_d    = point_x_i;
                py_d    = point_y_i;
                issue_d = '0;
                first_d = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read per cycle, then drain the pipeline
        if (issue_q < count_q) begin
          ram_re  = 1'b1;
          issue_d = issue_q + CNT_W'(1);
        end else if (!rd_v_q && !diff_v_q && !sq_v_q) begin
          res_v_d = 1'b1;
          stat_d  = STAT_OK;
          rid_d   = best_id_q;
          rdist_d = best_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      issue_q  <= '0;
      first_q  <= 1'b1;
      rd_v_q   <= 1'b0;
      diff_v_q <= 1'b0;
      sq_v_q   <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      first_q  <= first_d;
      rd_v_q   <= ram_re;
      diff_v_q <= rd_v_q;
      sq_v_q   <= diff_v_q;
      res_v_q  <= res_v_d;
    end
  end

  // Payload registers and pipeline stages
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    magx_q    <= magx;
    magy_q    <= magy;
    id_diff_q <= rentry.id;
    sqx_q     <= magx_q * magx_q;
    sqy_q     <= magy_q * magy_q;
    id_sq_q   <= id_diff_q;
    best_q    <= best_d;
    best_id_q <= best_id_d;
    stat_q    <= stat_d;
    rid_q     <= rid_d;
    rdist_q   <= rdist_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_v_q;
  assign status_o       = stat_q;
  assign nearest_id_o   = rid_q;
  assign best_dist_sq_o = rdist_q;

endmodule
